// ----- rtl/core/mecanum_move_sequencer_unit_assert.svh -----
// Assertion macros shared by the move sequencer RTL.
`ifndef MECANUM_MOVE_SEQUENCER_UNIT_ASSERT_SVH
`define MECANUM_MOVE_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mms assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define MMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mms assertion failed");

`endif

// ----- rtl/core/mms_pkg.sv -----
// Types, codes and constants of the mecanum move sequencer.
package mms_pkg;

  typedef enum logic [1:0] {
    ACT_DIST  = 2'd0,
    ACT_MULTI = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_W = 2'd2
  } axis_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         axis;
    logic signed [15:0] distance_cm;
    logic signed [15:0] axis_speed;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_w;
    logic signed [31:0] target_count;
    logic signed [31:0] encoder_value;
  } in_item_t;

  typedef struct packed {
    logic       port;
    logic [7:0] command;
    logic [7:0] value;
    logic       has_value;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_START = 2'd0,
    JOB_CONT  = 2'd1,
    JOB_STOP  = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t       kind;
    logic            read_first;
    logic [3:0][7:0] speed;
  } job_t;

  localparam int     COEF_FRAC_BITS_DEF = 16;
  localparam int     QUEUE_DEPTH_DEF    = 4;
  // 0.355*pi/180 in Q32
  localparam longint COEF_Q32           = 64'd26611269;

  // cm to count: *998, then /35 as multiply by ceil(2^31/35) and shift
  localparam logic [9:0]  DIST_SCALE = 10'd998;
  localparam logic [25:0] DIV_MUL    = 26'd61356676;
  localparam int          DIV_SHIFT  = 31;

  localparam logic [7:0] SPEED_STOP    = 8'd128;
  localparam logic [7:0] CMD_SPEED_B   = 8'h31;
  localparam logic [7:0] CMD_SPEED_A   = 8'h32;
  localparam logic [7:0] CMD_ENC_RESET = 8'h35;
  localparam logic [7:0] CMD_READ_ENC1 = 8'h23;
  localparam logic [7:0] CMD_READ_ENC2 = 8'h24;

  // last frame index of each job kind
  localparam logic [2:0] IDX_START_LAST = 3'd2;
  localparam logic [2:0] IDX_STOP_LAST  = 3'd3;
  localparam logic [2:0] IDX_CONT_LAST  = 3'd4;

endpackage

// ----- rtl/core/mecanum_move_sequencer_unit.sv -----
// Top level of the mecanum move sequencer: front end, job queue, back end.
//
// Usage:
//  - req channel (req_valid/req_ready/req_data) takes move requests
//    (distance or multi move) and encoder readings, one per cycle while req_ready is high.
//  - frm channel (frm_valid/frm_ready/frm_data) gives command frames for the
//    wheel drivers, one per cycle while frm_ready is high, last set on a
//    request's final frame.
//  - A request's first frame passes the three front-end stages, the job queue
//    and the output register before it is valid. A move request gives 3
//    frames, a reading 4 (stop) or 5 (continue), an idle reading or action
//    code three none; the back end's frame expansion sets the sustained rate.
//  - The front end is a three-stage pipeline (decode and multiply, wheel mix
//    and distance scaling, sign fix and move tracking); a job queue decouples
//    it from frame emission, so requests keep flowing until the queue fills.
//  - Reset (rst, synchronous): idle, goal zero, encoder one selected, wheel
//    speeds 128, queue and output register empty.
//  - When the receiver stalls, the current frame holds in the output register,
//    the queue fills, then req_ready drops until space frees up.
module mecanum_move_sequencer_unit #(
  parameter int COEF_FRAC_BITS = mms_pkg::COEF_FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH    = mms_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  mms_pkg::in_item_t  req_data,
  output logic               frm_valid,
  input  logic               frm_ready,
  output mms_pkg::out_item_t frm_data
);

  // front -> queue
  logic          push_valid;
  logic          push_ready;
  mms_pkg::job_t push_job;

  // queue -> back
  logic          pop_valid;
  logic          pop_ready;
  mms_pkg::job_t pop_job;

  mms_front #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .job_valid(push_valid),
    .job_ready(push_ready),
    .job      (push_job)
  );

  mms_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_job),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_job)
  );

  mms_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(pop_valid),
    .job_ready(pop_ready),
    .job      (pop_job),
    .frm_valid(frm_valid),
    .frm_ready(frm_ready),
    .frm_data (frm_data)
  );

endmodule

// ----- rtl/core/mms_front.sv -----
// Front end: accepts requests, mixes wheel speeds, tracks the move, issues jobs.
module mms_front #(
  parameter int COEF_FRAC_BITS = mms_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  mms_pkg::in_item_t req_data,
  output logic             job_valid,
  input  logic             job_ready,
  output mms_pkg::job_t    job
);

  localparam longint COEF = (mms_pkg::COEF_Q32 + (longint'(1) << (31 - COEF_FRAC_BITS)))
                            >> (32 - COEF_FRAC_BITS);
  localparam int COEF_W = $clog2(COEF + 1) + 1;
  localparam int ROT_W  = 16 + COEF_W;
  localparam int T_W    = COEF_FRAC_BITS + 19;
  localparam int Q_W    = T_W - COEF_FRAC_BITS;
  localparam logic signed [COEF_W-1:0] COEF_S = COEF_W'(COEF);

  // sum in Q(frac), truncate toward zero, clamp, offset by 128
  function automatic logic [7:0] wheel(input logic signed [16:0] lin,
                                       input logic signed [ROT_W-1:0] rot,
                                       input logic add);
    logic signed [T_W-1:0] t;
    logic [T_W-1:0]        mag;
    logic [Q_W-1:0]        q;
    t = T_W'(lin) <<< COEF_FRAC_BITS;
    if (add) begin
      t = t + T_W'(rot);
    end else begin
      t = t - T_W'(rot);
    end
    mag = t[T_W-1] ? -t : t;
    q   = mag[T_W-1:COEF_FRAC_BITS];
    if (!t[T_W-1]) begin
      wheel = (q > Q_W'(127)) ? 8'd255 : 8'(q) + 8'd128;
    end else begin
      wheel = (q > Q_W'(128)) ? 8'd0 : 8'(9'd128 - 9'(q));
    end
  endfunction

  logic adv;
  logic accept;

  // request decode
  logic signed [15:0] x, y, w;
  logic signed [31:0] cnt;
  logic               use_div;
  logic [15:0]        dist_mag;

  always_comb begin
    x       = req_data.vel_x;
    y       = req_data.vel_y;
    w       = req_data.vel_w;
    cnt     = req_data.target_count;
    use_div = 1'b0;
    if (req_data.action == mms_pkg::ACT_DIST) begin
      x   = '0;
      y   = '0;
      w   = '0;
      cnt = 32'(req_data.distance_cm);
      case (req_data.axis)
        mms_pkg::AXIS_X: begin
          x       = req_data.axis_speed;
          use_div = 1'b1;
        end
        mms_pkg::AXIS_Y: begin
          y       = req_data.axis_speed;
          use_div = 1'b1;
        end
        default: begin
          w = req_data.axis_speed;
        end
      endcase
    end
    dist_mag = req_data.distance_cm[15] ? (~req_data.distance_cm + 16'd1)
                                        : req_data.distance_cm;
  end

  assign accept = req_valid && adv;

  // stage 1
  logic                    v1, read1, use_div1, neg1;
  logic signed [16:0]      lin_a1, lin_b1;
  logic signed [ROT_W-1:0] rot1;
  logic [24:0]             prod1;
  logic signed [31:0]      cnt1, enc1;

  // stage 2
  logic                    v2, read2;
  logic [3:0][7:0]         sp2;
  logic signed [31:0]      cnt2, enc2;
  logic [50:0]             div_prod;
  logic [19:0]             div_q;

  // stage 3
  logic                    v3, read3;
  logic [3:0][7:0]         sp3;
  logic signed [31:0]      cnt3, enc3;

  // move state
  logic                    moving;
  logic signed [31:0]      goal;
  logic                    read_first;
  logic [3:0][7:0]         wheel_speed;

  assign div_prod = 51'(prod1) * 51'(mms_pkg::DIV_MUL);
  assign div_q    = div_prod[mms_pkg::DIV_SHIFT +: 20];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= accept && (req_data.action inside {mms_pkg::ACT_DIST, mms_pkg::ACT_MULTI,
                                               mms_pkg::ACT_READ});
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      read1    <= (req_data.action == mms_pkg::ACT_READ);
      use_div1 <= use_div;
      neg1     <= req_data.distance_cm[15];
      lin_a1   <= 17'(x) - 17'(y);
      lin_b1   <= 17'(x) + 17'(y);
      rot1     <= ROT_W'(w) * ROT_W'(COEF_S);
      prod1    <= 25'(dist_mag) * 25'(mms_pkg::DIST_SCALE);
      cnt1     <= cnt;
      enc1     <= req_data.encoder_value;

      read2    <= read1;
      sp2[0]   <= wheel(lin_a1, rot1, 1'b0);
      sp2[1]   <= wheel(lin_b1, rot1, 1'b1);
      sp2[2]   <= wheel(lin_b1, rot1, 1'b0);
      sp2[3]   <= wheel(lin_a1, rot1, 1'b1);
      cnt2     <= use_div1 ? (neg1 ? -32'(div_q) : 32'(div_q)) : cnt1;
      enc2     <= enc1;

      read3    <= read2;
      sp3      <= sp2;
      cnt3     <= cnt2;
      enc3     <= enc2;
    end
  end

  // sign fix and continue test
  logic               rf_new, neg_goal, go, need_job;
  logic signed [31:0] goal_new;

  always_comb begin
    rf_new   = (sp3[1] != mms_pkg::SPEED_STOP);
    neg_goal = rf_new ? (sp3[1] > mms_pkg::SPEED_STOP) : (sp3[0] > mms_pkg::SPEED_STOP);
    goal_new = neg_goal ? -cnt3 : cnt3;
    go       = (goal > 32'sd0) ? (goal > enc3) : (goal < enc3);
    need_job = v3 && (!read3 || moving);

    job.read_first = read_first;
    job.speed      = wheel_speed;
    if (!read3) begin
      job.kind       = mms_pkg::JOB_START;
      job.read_first = rf_new;
      job.speed      = sp3;
    end else if (go) begin
      job.kind = mms_pkg::JOB_CONT;
    end else begin
      job.kind = mms_pkg::JOB_STOP;
    end
  end

  assign adv       = !need_job || job_ready;
  assign job_valid = need_job;
  assign req_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      moving      <= 1'b0;
      goal        <= '0;
      read_first  <= 1'b1;
      wheel_speed <= {4{mms_pkg::SPEED_STOP}};
    end else if (v3 && adv) begin
      if (!read3) begin
        moving      <= 1'b1;
        goal        <= goal_new;
        read_first  <= rf_new;
        wheel_speed <= sp3;
      end else if (moving && !go) begin
        moving <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/mms_queue.sv -----
// Job queue between front and back end.
`include "mecanum_move_sequencer_unit_assert.svh"

module mms_queue #(
  parameter int DEPTH = mms_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  mms_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output mms_pkg::job_t pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mms_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `MMS_ASSERT_NOW(a_q_bound, 1'b1, count <= CW'(DEPTH))
  `MMS_ASSERT_NEXT(a_q_fill, do_push && !do_pop, count == $past(count) + 1'b1)
  `MMS_ASSERT_NEXT(a_q_drain, do_pop && !do_push, count == $past(count) - 1'b1)

endmodule

// ----- rtl/core/mms_back.sv -----
// Back end: expands each job into command frames behind an output register.
`include "mecanum_move_sequencer_unit_assert.svh"

module mms_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_ready,
  input  mms_pkg::job_t      job,
  output logic               frm_valid,
  input  logic               frm_ready,
  output mms_pkg::out_item_t frm_data
);

  logic [2:0]         idx;
  mms_pkg::out_item_t frame;
  logic               is_last;
  logic               load;
  logic [7:0]         read_cmd;
  logic [7:0]         speed_cmd;
  logic [7:0]         cur_speed;

  always_comb begin
    read_cmd  = job.read_first ? mms_pkg::CMD_READ_ENC1 : mms_pkg::CMD_READ_ENC2;
    speed_cmd = idx[0] ? mms_pkg::CMD_SPEED_B : mms_pkg::CMD_SPEED_A;
    cur_speed = job.speed[idx[1:0]];

    frame.port      = idx[1];
    frame.command   = speed_cmd;
    frame.value     = mms_pkg::SPEED_STOP;
    frame.has_value = 1'b1;
    frame.last      = 1'b0;
    is_last         = 1'b0;

    case (job.kind)
      mms_pkg::JOB_START: begin
        frame.port      = 1'b0;
        frame.value     = '0;
        frame.has_value = 1'b0;
        frame.command   = mms_pkg::CMD_ENC_RESET;
        if (idx == mms_pkg::IDX_START_LAST) begin
          frame.command = read_cmd;
          is_last       = 1'b1;
        end
      end
      mms_pkg::JOB_CONT: begin
        // negated speed byte, modulo 256
        frame.value = ~cur_speed + 8'd1;
        if (idx == mms_pkg::IDX_CONT_LAST) begin
          frame.port      = 1'b0;
          frame.command   = read_cmd;
          frame.value     = '0;
          frame.has_value = 1'b0;
          is_last         = 1'b1;
        end
      end
      mms_pkg::JOB_STOP: begin
        is_last = (idx == mms_pkg::IDX_STOP_LAST);
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
    frame.last = is_last;
  end

  assign load      = job_valid && (!frm_valid || frm_ready);
  assign job_ready = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      frm_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      frm_valid <= 1'b1;
      idx       <= is_last ? '0 : idx + 3'd1;
    end else if (frm_ready) begin
      frm_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frm_data <= frame;
    end
  end

  `MMS_ASSERT_NOW(a_idx_range, 1'b1, idx <= mms_pkg::IDX_CONT_LAST)
  `MMS_ASSERT_NEXT(a_idx_wrap, load && is_last, idx == '0)
  `MMS_ASSERT_NEXT(a_frm_load, load, frm_valid && (frm_data == $past(frame)))

endmodule

// ----- dv/tb.sv -----
// Testbench for the mecanum move sequencer: random-stall driving, frame prediction, checking.
module tb;
  import mms_pkg::*;

  localparam int QUIET_LIMIT     = 3000; // cycles with no transfer on either side
  localparam int DRAIN_CYCLES    = 40;   // extra cycles after the last expected frame
  localparam int ITEMS_PER_PHASE = 132;  // items sent per random phase

  // codes with no package name
  localparam logic [1:0] ACT_NONE   = 2'd3;
  localparam logic [1:0] AXIS_ALT_W = 2'd3;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  in_item_t  req_data  = '0;
  logic      req_ready;
  logic      frm_valid;
  logic      frm_ready = 1'b0;
  out_item_t frm_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_items    = 0;
  int quiet_cycles  = 0;

  // Tracks the move state and queues the frames each accepted item should cause.
  class move_frame_model;
    localparam int     FRAC     = COEF_FRAC_BITS_DEF;
    localparam longint ROT_COEF = (COEF_Q32 + (64'd1 << (31 - FRAC))) >>> (32 - FRAC);
    localparam longint CM_NUM   = 998;
    localparam longint CM_DEN   = 35;

    out_item_t   pending_frames[$];
    bit          moving;
    logic [31:0] goal_count;
    bit          read_first;
    logic [7:0]  speeds[4];
    int          errors, n_moves, n_conts, n_stops, n_ignored, n_frames;

    function new();
      moving     = 1'b0;
      goal_count = '0;
      read_first = 1'b1;
      foreach (speeds[i]) speeds[i] = SPEED_STOP;
    endfunction

    task report(string msg);
      if (errors < 100) $display("tb: mismatch: %s", msg);
      errors++;
    endtask

    function void push_frame(bit port, logic [7:0] cmd, logic [7:0] val, bit hv, bit last);
      out_item_t f;
      f.port      = port;
      f.command   = cmd;
      f.value     = val;
      f.has_value = hv;
      f.last      = last;
      pending_frames.push_back(f);
    endfunction

    // Q(FRAC) sum, truncated toward zero, clamped, offset to the stop code
    function logic [7:0] mix_wheel(longint lin, longint rot, bit add_rot);
      longint t;
      longint r;
      t = lin * (longint'(1) << FRAC);
      t = add_rot ? t + rot : t - rot;
      if (t < 0) r = -((-t) >>> FRAC);
      else r = t >>> FRAC;
      if (r > 127) r = 127;
      if (r < -128) r = -128;
      return 8'(r + 128);
    endfunction

    function void start_move(longint x, longint y, longint w, longint count);
      longint      rot;
      logic [31:0] g;
      rot = w * ROT_COEF;
      g   = 32'(count);
      speeds[0] = mix_wheel(x - y, rot, 1'b0);
      speeds[1] = mix_wheel(x + y, rot, 1'b1);
      speeds[2] = mix_wheel(x + y, rot, 1'b0);
      speeds[3] = mix_wheel(x - y, rot, 1'b1);
      // wheel 1 picks encoder one and the sign unless it is stopped
      if (speeds[1] != SPEED_STOP) begin
        read_first = 1'b1;
        if (speeds[1] > SPEED_STOP) g = -g;
      end else begin
        read_first = 1'b0;
        if (speeds[0] > SPEED_STOP) g = -g;
      end
      goal_count = g;
      moving     = 1'b1;
      n_moves++;
      push_frame(1'b0, CMD_ENC_RESET, 8'd0, 1'b0, 1'b0);
      push_frame(1'b0, CMD_ENC_RESET, 8'd0, 1'b0, 1'b0);
      push_frame(1'b0, read_first ? CMD_READ_ENC1 : CMD_READ_ENC2, 8'd0, 1'b0, 1'b1);
    endfunction

    // returns the number of frames the item causes
    function int note_input(in_item_t it);
      int  before_n;
      int  gs;
      int  e;
      bit  go;
      before_n = pending_frames.size();
      case (it.action)
        ACT_DIST: begin
          case (it.axis)
            AXIS_X:  start_move(it.axis_speed, 0, 0,
                                longint'(it.distance_cm) * CM_NUM / CM_DEN);
            AXIS_Y:  start_move(0, it.axis_speed, 0,
                                longint'(it.distance_cm) * CM_NUM / CM_DEN);
            default: start_move(0, 0, it.axis_speed, it.distance_cm);
          endcase
        end
        ACT_MULTI: start_move(it.vel_x, it.vel_y, it.vel_w, it.target_count);
        ACT_READ: begin
          if (!moving) begin
            n_ignored++;
          end else begin
            gs = int'(goal_count);
            e  = it.encoder_value;
            go = (gs > 0) ? (gs > e) : (gs < e);
            if (go) begin
              n_conts++;
              push_frame(1'b0, CMD_SPEED_A, -speeds[0], 1'b1, 1'b0);
              push_frame(1'b0, CMD_SPEED_B, -speeds[1], 1'b1, 1'b0);
              push_frame(1'b1, CMD_SPEED_A, -speeds[2], 1'b1, 1'b0);
              push_frame(1'b1, CMD_SPEED_B, -speeds[3], 1'b1, 1'b0);
              push_frame(1'b0, read_first ? CMD_READ_ENC1 : CMD_READ_ENC2, 8'd0, 1'b0, 1'b1);
            end else begin
              n_stops++;
              moving = 1'b0;
              push_frame(1'b0, CMD_SPEED_A, SPEED_STOP, 1'b1, 1'b0);
              push_frame(1'b0, CMD_SPEED_B, SPEED_STOP, 1'b1, 1'b0);
              push_frame(1'b1, CMD_SPEED_A, SPEED_STOP, 1'b1, 1'b0);
              push_frame(1'b1, CMD_SPEED_B, SPEED_STOP, 1'b1, 1'b1);
            end
          end
        end
        default: n_ignored++;
      endcase
      return pending_frames.size() - before_n;
    endfunction

    task check_frame(out_item_t got);
      out_item_t exp_f;
      n_frames++;
      if (pending_frames.size() == 0) begin
        report($sformatf("unexpected frame %h", got));
      end else begin
        exp_f = pending_frames.pop_front();
        if (got.port != exp_f.port)
          report($sformatf("frame %0d port %0d, want %0d", n_frames, got.port, exp_f.port));
        if (got.command != exp_f.command)
          report($sformatf("frame %0d command %h, want %h", n_frames, got.command,
                           exp_f.command));
        if (got.value != exp_f.value)
          report($sformatf("frame %0d value %0d, want %0d", n_frames, got.value, exp_f.value));
        if (got.has_value != exp_f.has_value)
          report($sformatf("frame %0d has_value %0d, want %0d", n_frames, got.has_value,
                           exp_f.has_value));
        if (got.last != exp_f.last)
          report($sformatf("frame %0d last %0d, want %0d", n_frames, got.last, exp_f.last));
      end
    endtask
  endclass

  move_frame_model model = new();

  mecanum_move_sequencer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm_data  (frm_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    frm_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && frm_valid && frm_ready) model.check_frame(frm_data);
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (frm_valid && frm_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: no transfer for %0d cycles", QUIET_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // called just after a rising edge; returns just after the transfer edge
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= it;
    do @(posedge clk); while (!req_ready);
    void'(model.note_input(it));
    sent_items++;
  endtask

  function automatic logic signed [15:0] rand16();
    case ($urandom_range(9))
      0:       return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
      1:       return ($urandom_range(1)) ? 16'sh0000 : 16'shffff;
      2, 3, 4: return 16'($urandom_range(600) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] rand32();
    case ($urandom_range(9))
      0:       return ($urandom_range(1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
      1, 2, 3: return 32'($urandom_range(20000) - 10000);
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_fields();
    in_item_t it;
    it.action        = 2'($urandom);
    it.axis          = 2'($urandom);
    it.distance_cm   = 16'($urandom);
    it.axis_speed    = 16'($urandom);
    it.vel_x         = 16'($urandom);
    it.vel_y         = 16'($urandom);
    it.vel_w         = 16'($urandom);
    it.target_count  = 32'($urandom);
    it.encoder_value = 32'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_request();
    in_item_t it;
    it = rand_fields();
    it.action       = $urandom_range(1) ? ACT_MULTI : ACT_DIST;
    it.axis         = 2'($urandom_range(3));
    it.distance_cm  = rand16();
    it.axis_speed   = rand16();
    it.vel_x        = rand16();
    it.vel_y        = rand16();
    it.vel_w        = rand16();
    it.target_count = rand32();
    // cancel x and y on wheel 1 so the encoder-two path comes up
    if ($urandom_range(7) == 0) begin
      it.vel_y = -it.vel_x;
      it.vel_w = 16'($urandom_range(300) - 150);
    end
    return it;
  endfunction

  // reading aimed at the current goal: mostly keeps the move going
  function automatic in_item_t make_reading();
    in_item_t it;
    int       g;
    int       roll;
    it        = rand_fields();
    it.action = ACT_READ;
    g         = int'(model.goal_count);
    roll      = $urandom_range(99);
    if (roll < 65)
      it.encoder_value = (g > 0) ? g - $urandom_range(1, 2000) : g + $urandom_range(1, 2000);
    else if (roll < 85)
      it.encoder_value = (g > 0) ? g + $urandom_range(2000) : g - $urandom_range(2000);
    else if (roll < 90)
      it.encoder_value = g;
    return it;
  endfunction

  function automatic in_item_t mk_dist(logic [1:0] ax, logic signed [15:0] d,
                                       logic signed [15:0] s);
    in_item_t it;
    it             = '0;
    it.action      = ACT_DIST;
    it.axis        = ax;
    it.distance_cm = d;
    it.axis_speed  = s;
    return it;
  endfunction

  function automatic in_item_t mk_multi(logic signed [15:0] x, logic signed [15:0] y,
                                        logic signed [15:0] w, logic signed [31:0] t);
    in_item_t it;
    it              = '0;
    it.action       = ACT_MULTI;
    it.vel_x        = x;
    it.vel_y        = y;
    it.vel_w        = w;
    it.target_count = t;
    return it;
  endfunction

  function automatic in_item_t mk_read(logic signed [31:0] e);
    in_item_t it;
    it               = '0;
    it.action        = ACT_READ;
    it.encoder_value = e;
    return it;
  endfunction

  // Random sequences: a request then a few readings; some noise in between.
  task automatic run_phase(int s_idle, int r_idle, int count);
    int stop_at;
    int n;
    in_item_t it;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    stop_at       = sent_items + count;
    while (sent_items < stop_at) begin
      if ($urandom_range(99) < 8) begin
        it = rand_fields();
        if ($urandom_range(1)) it.action = ACT_NONE;
        else it = make_reading();
        send_item(it);
      end else begin
        send_item(make_request());
        n = $urandom_range(6);
        repeat (n) send_item(make_reading());
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 30;
    recv_idle_pct = 76;

    // directed: idle reading, unused action, field extremes, both encoders, replacement
    send_item(mk_read(32'sd0));
    send_item('1);
    send_item(mk_dist(AXIS_X, 16'sd100, 16'sd50));
    send_item(mk_read(32'sd0));
    send_item(mk_read(32'sh7fff_ffff));
    send_item(mk_dist(AXIS_X, 16'sh8000, 16'sh8000));
    send_item(mk_read(32'sd0));
    send_item(mk_read(32'sh8000_0000));
    send_item(mk_dist(AXIS_Y, 16'sh7fff, 16'sh7fff));
    send_item(mk_read(32'sd0));
    send_item(mk_dist(AXIS_W, -16'sd5, 16'sh7fff));
    send_item(mk_read(-32'sd5));
    send_item(mk_dist(AXIS_ALT_W, 16'sd0, -16'sd300));
    send_item(mk_read(32'sd0));
    send_item(mk_multi(16'sd0, 16'sd0, 16'sd0, 32'sd0));
    send_item(mk_read(32'sd0));
    send_item(mk_multi(16'sd5, -16'sd5, 16'sd0, 32'sh8000_0000));
    send_item(mk_read(32'sd0));
    send_item(mk_multi(16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sh7fff_ffff));
    send_item(mk_read(32'sh8000_0000));
    send_item(mk_read(32'sh7fff_ffff));
    send_item(mk_multi(16'sh8000, 16'sh8000, 16'sh8000, 32'sd1));
    send_item(mk_dist(AXIS_Y, -16'sd1, 16'sd1));
    send_item(mk_read(32'sd1));
    send_item(mk_read(32'sd0));

    run_phase(30, 76, ITEMS_PER_PHASE);
    run_phase(76, 30, ITEMS_PER_PHASE);
    run_phase(0, 0, ITEMS_PER_PHASE);
    req_valid <= 1'b0;

    while (model.pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d moves started, %0d readings continued, %0d stopped, %0d items ignored",
             model.n_moves, model.n_conts, model.n_stops, model.n_ignored);
    $display("tb: %0d frames compared, %0d mismatches", model.n_frames, model.errors);
    if (model.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
